[hw/rtl/positional_pid_clamped_macros.svh]
// Assertion macros shared by the positional PID block.
`ifndef POSITIONAL_PID_CLAMPED_MACROS_SVH
`define POSITIONAL_PID_CLAMPED_MACROS_SVH

`ifndef ASSERT_OFF
// Checked on every rising edge, switched off while reset is asserted
`define PPC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checked on every rising edge, reset included
`define PPC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define PPC_ASSERT(lbl, prop, msg)
`define PPC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[hw/rtl/ppc_pkg.sv]
// Shared widths, register map and types for the positional PID block.
package ppc_pkg;

    // Field widths
    localparam int DATA_W     = 16;
    localparam int ERR_W      = DATA_W + 1;
    localparam int DIFF_W     = ERR_W + 1;
    localparam int SUM_W      = 32;
    localparam int GAIN_S_W   = DATA_W + 1;
    localparam int FRAC_BITS  = 4;

    // Product and accumulator widths (exact, no rounding)
    localparam int PROD_P_W   = GAIN_S_W + ERR_W;
    localparam int PROD_I_W   = GAIN_S_W + SUM_W;
    localparam int PROD_D_W   = GAIN_S_W + DIFF_W;
    localparam int ACC_W      = PROD_I_W + 2;

    // APB port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;
    localparam int REG_IDX_W  = 2;

    // Register reset values
    localparam logic [DATA_W-1:0] GAIN_P_RST  = 16'd240;
    localparam logic [DATA_W-1:0] GAIN_I_RST  = 16'd96;
    localparam logic [DATA_W-1:0] GAIN_D_RST  = 16'd320;
    localparam logic [DATA_W-1:0] OUT_MAX_RST = 16'd1000;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_GAIN_P  = 2'd0,
        REG_GAIN_I  = 2'd1,
        REG_GAIN_D  = 2'd2,
        REG_OUT_MAX = 2'd3
    } ppc_reg_idx_t;

    typedef struct packed {
        logic [DATA_W-1:0] gain_p;
        logic [DATA_W-1:0] gain_i;
        logic [DATA_W-1:0] gain_d;
        logic [DATA_W-1:0] output_max;
    } ppc_cfg_t;

    typedef struct packed {
        logic [DATA_W-1:0] drive;
        logic              clamp;
    } ppc_res_t;

endpackage

[hw/rtl/ppc_sample_if.sv]
// Input channel: setpoint and measurement word with valid/ready.
interface ppc_sample_if;
    import ppc_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] setpoint;
    logic [DATA_W-1:0] measurement;

    modport source (output valid, output setpoint, output measurement, input ready);
    modport sink   (input valid, input setpoint, input measurement, output ready);
endinterface

[hw/rtl/ppc_result_if.sv]
// Output channel: drive word with valid/ready.
interface ppc_result_if;
    import ppc_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] drive;

    modport source (output valid, output drive, input ready);
    modport sink   (input valid, input drive, output ready);
endinterface

[hw/rtl/ppc_regs.sv]
// APB configuration registers: gains and drive limit.
module ppc_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ppc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [ppc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ppc_pkg::APB_DATA_W-1:0]     prdata,
    output ppc_pkg::ppc_cfg_t                  cfg
);
    import ppc_pkg::*;

    ppc_cfg_t     cfg_reg;
    ppc_cfg_t     cfg_next;
    ppc_reg_idx_t idx;
    logic         wr_en;

    assign idx   = ppc_reg_idx_t'(paddr[REG_IDX_W+1:2]);
    assign wr_en = psel && penable && pwrite;

    // Write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_GAIN_P:  cfg_next.gain_p     = pwdata[DATA_W-1:0];
                REG_GAIN_I:  cfg_next.gain_i     = pwdata[DATA_W-1:0];
                REG_GAIN_D:  cfg_next.gain_d     = pwdata[DATA_W-1:0];
                REG_OUT_MAX: cfg_next.output_max = pwdata[DATA_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p     <= GAIN_P_RST;
            cfg_reg.gain_i     <= GAIN_I_RST;
            cfg_reg.gain_d     <= GAIN_D_RST;
            cfg_reg.output_max <= OUT_MAX_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read mux
    always_comb
    begin
        unique case (idx)
            REG_GAIN_P:  prdata = APB_DATA_W'(cfg_reg.gain_p);
            REG_GAIN_I:  prdata = APB_DATA_W'(cfg_reg.gain_i);
            REG_GAIN_D:  prdata = APB_DATA_W'(cfg_reg.gain_d);
            REG_OUT_MAX: prdata = APB_DATA_W'(cfg_reg.output_max);
        endcase
    end

    assign cfg = cfg_reg;

endmodule

[hw/rtl/ppc_core.sv]
// PID datapath: error, saturating integral, three products, clamp; holds the loop state.
module ppc_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ppc_pkg::ppc_cfg_t             cfg,
    input  logic                          fire,
    input  logic [ppc_pkg::DATA_W-1:0]    setpoint,
    input  logic [ppc_pkg::DATA_W-1:0]    measurement,
    output ppc_pkg::ppc_res_t             res
);
    import ppc_pkg::*;

    logic signed [SUM_W-1:0]    error_sum_reg;
    logic signed [SUM_W-1:0]    error_sum_next;
    logic signed [ERR_W-1:0]    prev_err_reg;

    logic signed [ERR_W-1:0]    err;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [SUM_W:0]      sum_wide;
    logic signed [SUM_W-1:0]    sum_sat;
    logic signed [GAIN_S_W-1:0] gp_s;
    logic signed [GAIN_S_W-1:0] gi_s;
    logic signed [GAIN_S_W-1:0] gd_s;
    logic signed [PROD_P_W-1:0] prod_p;
    logic signed [PROD_I_W-1:0] prod_i;
    logic signed [PROD_D_W-1:0] prod_d;
    logic signed [ACC_W-1:0]    acc;
    logic signed [ACC_W-1:0]    limit;
    logic                       low_clamp;
    logic                       high_clamp;

    // Error and derivative term
    assign err  = $signed({1'b0, setpoint}) - $signed({1'b0, measurement});
    assign diff = DIFF_W'(err) - DIFF_W'(prev_err_reg);

    // Integral with saturation at the 32-bit signed range
    assign sum_wide = (SUM_W+1)'(error_sum_reg) + (SUM_W+1)'(err);
    always_comb
    begin
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
            sum_sat = {sum_wide[SUM_W], {(SUM_W-1){~sum_wide[SUM_W]}}};
        else
            sum_sat = sum_wide[SUM_W-1:0];
    end

    // Three independent products, gains taken as non-negative
    assign gp_s   = $signed({1'b0, cfg.gain_p});
    assign gi_s   = $signed({1'b0, cfg.gain_i});
    assign gd_s   = $signed({1'b0, cfg.gain_d});
    assign prod_p = gp_s * err;
    assign prod_i = gi_s * sum_sat;
    assign prod_d = gd_s * diff;

    // Q.4 accumulator, exact; the drive word is its integer part
    assign acc   = ACC_W'(prod_p) + ACC_W'(prod_i) + ACC_W'(prod_d);
    assign limit = $signed(ACC_W'({cfg.output_max, {FRAC_BITS{1'b0}}}));

    assign low_clamp  = acc[ACC_W-1] || (acc == '0);
    assign high_clamp = !low_clamp && (acc >= limit);

    // Clamp and integral reset
    always_comb
    begin
        res.clamp = low_clamp || high_clamp;
        priority if (low_clamp)
            res.drive = '0;
        else if (high_clamp)
            res.drive = cfg.output_max;
        else
            res.drive = acc[FRAC_BITS +: DATA_W];
        error_sum_next = res.clamp ? '0 : sum_sat;
    end

    // Loop state, advanced once per word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_sum_reg <= '0;
            prev_err_reg  <= '0;
        end
        else if (fire)
        begin
            error_sum_reg <= error_sum_next;
            prev_err_reg  <= err;
        end
    end

endmodule

[hw/rtl/positional_pid_clamped.sv]
// Positional PID drive with clamp and integral reset, top level.
// A word passes from the input register through the core into the output register on the result port.
// Throughput: one word per cycle unless the output stalls; integral and last error feed back in that cycle.
// The input register can still take a new word while a finished drive waits on the output register.
// Reset (rst_n, asynchronous, active low) clears integral, last error and valid flags,
// and loads the gain and limit registers with their defaults.
`include "positional_pid_clamped_macros.svh"

module positional_pid_clamped (
    input  logic                               clk,
    input  logic                               rst_n,
    ppc_sample_if.sink                         sample,
    ppc_result_if.source                       result,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ppc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [ppc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ppc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);
    import ppc_pkg::*;

    ppc_cfg_t          cfg;
    ppc_res_t          res;

    logic              in_valid_reg;
    logic [DATA_W-1:0] setpoint_reg;
    logic [DATA_W-1:0] measurement_reg;
    logic              out_valid_reg;
    logic [DATA_W-1:0] drive_reg;
    logic              in_take;
    logic              core_fire;

    assign pready = 1'b1;

    ppc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    ppc_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .fire        (core_fire),
        .setpoint    (setpoint_reg),
        .measurement (measurement_reg),
        .res         (res)
    );

    // Handshake: the input stage moves on when the output register is free or being drained
    assign core_fire    = in_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !in_valid_reg || core_fire;
    assign in_take      = sample.valid && sample.ready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (sample.ready)
            in_valid_reg <= sample.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            setpoint_reg    <= sample.setpoint;
            measurement_reg <= sample.measurement;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (core_fire)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (core_fire)
            drive_reg <= res.drive;
    end

    assign result.valid = out_valid_reg;
    assign result.drive = drive_reg;

    // Checks
    `PPC_ASSERT(a_fire_fills_out, core_fire |=> out_valid_reg, "drive word lost after fire")
    `PPC_ASSERT(a_clamp_value, core_fire && res.clamp |=> (drive_reg == '0 || drive_reg == $past(cfg.output_max)), "clamped drive neither zero nor limit")
    `PPC_ASSERT(a_stall_cause, !sample.ready |-> in_valid_reg && out_valid_reg && !result.ready, "input stalled without a full pipe")
    `PPC_ASSERT_ALWAYS(a_reset_empty, !rst_n |-> !out_valid_reg && !in_valid_reg, "valid flags set in reset")

endmodule
